FILE: rtl/dss_pkg.sv
package dss_pkg;

    localparam int unsigned MAX_DELIM_DEFAULT = 8;
    localparam int unsigned DELIM_W           = 64;
    localparam int unsigned DLEN_W            = 4;
    localparam int unsigned SPLIT_W           = 16;
    localparam int unsigned CFG_IDX_W         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_LIMIT_EN    = 2'd2,
        CFG_SPLIT_LIMIT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DELIM_W-1:0] delim_bytes;
        logic [DLEN_W-1:0]  delim_len;
        logic               limit_en;
        logic [SPLIT_W-1:0] split_limit;
    } cfg_t;

    typedef struct packed {
        logic       string_last;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       string_end;
        logic       piece_end;
        logic       has_byte;
        logic [7:0] out_byte;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_CHECK,
        ST_TAIL
    } back_state_t;

endpackage

FILE: rtl/dss_front.sv
module dss_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // data_byte
    input  logic           s_tlast,   // string_last
    output logic           q_valid,
    output dss_pkg::item_t q_item,
    input  logic           q_pop
);
    import dss_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{string_last: s_tlast, data_byte: s_tdata};
        end
    end

endmodule

FILE: rtl/dss_back.sv
module dss_back #(
    parameter int unsigned MAX_DELIMITER_BYTES = dss_pkg::MAX_DELIM_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  dss_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  dss_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic [2:0]     m_tuser,   // has_byte, piece_end, string_end
    output logic           m_tlast    // run_last
);
    import dss_pkg::*;

    localparam int unsigned MAXD = MAX_DELIMITER_BYTES;
    localparam int unsigned CW   = $clog2(MAXD + 1);

    back_state_t         state_reg, state_next;
    logic [7:0]          hb_reg [MAXD];
    logic [CW-1:0]       mc_reg, mc_next;
    logic [SPLIT_W-1:0]  sp_reg, sp_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    res_t                pend_reg;
    logic                pend_vld_reg;
    res_t                out_reg;
    logic                out_last_reg;
    logic                out_vld_reg;

    logic [DLEN_W-1:0]   len_eff;
    logic                passthru;
    logic                match_ok;
    logic                out_free;
    logic                advance;
    logic                emit;
    logic                finalize;
    logic                shift;
    logic                append;
    res_t                res_new;

    assign len_eff  = (cfg.delim_len > DLEN_W'(MAXD)) ? DLEN_W'(MAXD) : cfg.delim_len;
    assign passthru = (len_eff == '0) || (cfg.limit_en && (sp_reg >= cfg.split_limit));
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = !pend_vld_reg || out_free;

    // held run still a prefix of the delimiter
    always_comb begin
        match_ok = (DLEN_W'(mc_reg) <= len_eff);
        for (int i = 0; i < MAXD; i++) begin
            if ((CW'(i) < mc_reg) && (hb_reg[i] != cfg.delim_bytes[8*i +: 8])) begin
                match_ok = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        mc_next    = mc_reg;
        sp_next    = sp_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        emit       = 1'b0;
        finalize   = 1'b0;
        shift      = 1'b0;
        append     = 1'b0;
        q_pop      = 1'b0;
        res_new    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (advance) begin
                    finalize = pend_vld_reg;
                    if (q_valid) begin
                        q_pop     = 1'b1;
                        byte_next = q_item.data_byte;
                        last_next = q_item.string_last;
                        if (passthru || (mc_reg == CW'(MAXD))) begin
                            state_next = ST_PASS;
                        end else begin
                            append     = 1'b1;
                            mc_next    = mc_reg + CW'(1);
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_PASS: begin
                if (advance) begin
                    emit             = 1'b1;
                    res_new.has_byte = 1'b1;
                    if (mc_reg != '0) begin
                        res_new.out_byte = hb_reg[0];
                        shift            = 1'b1;
                        mc_next          = mc_reg - CW'(1);
                    end else begin
                        res_new.out_byte = byte_reg;
                        state_next       = last_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_CHECK: begin
                if (advance) begin
                    if (match_ok) begin
                        if (DLEN_W'(mc_reg) == len_eff) begin
                            emit              = 1'b1;
                            res_new.piece_end = 1'b1;
                            mc_next           = '0;
                            if (sp_reg != '1) begin
                                sp_next = sp_reg + SPLIT_W'(1);
                            end
                        end
                        state_next = last_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        // release the oldest held byte, recheck the rest
                        emit             = 1'b1;
                        res_new.has_byte = 1'b1;
                        res_new.out_byte = hb_reg[0];
                        shift            = 1'b1;
                        mc_next          = mc_reg - CW'(1);
                        if (mc_reg == CW'(1)) begin
                            state_next = last_reg ? ST_TAIL : ST_IDLE;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (advance) begin
                    emit = 1'b1;
                    if (mc_reg != '0) begin
                        res_new.has_byte = 1'b1;
                        res_new.out_byte = hb_reg[0];
                        shift            = 1'b1;
                        mc_next          = mc_reg - CW'(1);
                    end else begin
                        res_new.piece_end  = 1'b1;
                        res_new.string_end = 1'b1;
                        sp_next            = '0;
                        state_next         = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mc_reg       <= '0;
            sp_reg       <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mc_reg    <= mc_next;
            sp_reg    <= sp_next;
            if (emit) begin
                pend_vld_reg <= 1'b1;
            end else if (finalize) begin
                pend_vld_reg <= 1'b0;
            end
            if ((emit && pend_vld_reg) || finalize) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // the newest result waits in pend_reg until it is known whether it ends the beat run
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (emit) begin
            pend_reg <= res_new;
        end
        if ((emit && pend_vld_reg) || finalize) begin
            out_reg      <= pend_reg;
            out_last_reg <= finalize;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAXD; i++) begin
            if (shift) begin
                if (i + 1 < MAXD) begin
                    hb_reg[i] <= hb_reg[(i + 1) % MAXD];
                end
            end else if (append && (mc_reg == CW'(i))) begin
                hb_reg[i] <= byte_next;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.string_end, out_reg.piece_end, out_reg.has_byte};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/delimiter_stream_splitter_unit.sv
// Splits a byte stream (one byte per s_ beat, s_tlast on the final byte of a string) into
// pieces at each leftmost, non-overlapping match of a delimiter of up to MAX_DELIMITER_BYTES
// bytes set through the cfg port (index 0 delimiter bytes, first byte in bits 7:0; 1 length,
// 0 = never split, values above the maximum are clamped; 2 limit enable; 3 split limit).
// Delimiter bytes are dropped; each split gives a mark beat (has_byte 0, piece_end 1) and the
// end of a string gives a mark with string_end 1 after any held bytes. m_tlast flags the last
// result beat caused by one input byte; a byte that may start a delimiter gives no beat until
// resolved. A two-entry input queue feeds a sequencer that makes at most one result per cycle
// while the output is not stalled: each byte is first loaded, then checked, with a further step for
// every held byte released or flushed. Write configuration only while the block is idle.
module delimiter_stream_splitter_unit #(
    parameter int unsigned MAX_DELIMITER_BYTES = dss_pkg::MAX_DELIM_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // data_byte
    input  logic                           s_tlast,    // string_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,    // out_byte
    output logic [2:0]                     m_tuser,    // has_byte, piece_end, string_end
    output logic                           m_tlast,    // run_last
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dss_pkg::DELIM_W-1:0]    cfg_data
);
    import dss_pkg::*;

    cfg_t  cfg_reg;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DELIM_BYTES: cfg_reg.delim_bytes <= cfg_data;
                CFG_DELIM_LEN:   cfg_reg.delim_len   <= cfg_data[DLEN_W-1:0];
                CFG_LIMIT_EN:    cfg_reg.limit_en    <= cfg_data[0];
                CFG_SPLIT_LIMIT: cfg_reg.split_limit <= cfg_data[SPLIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dss_back #(
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
